>>> hw/rtl/dcl_pkg.sv
// ----------------------------------------------------------------------------
// Dial combination lock package
// Shared constants, codes, word types and small helpers of the lock block.
// ----------------------------------------------------------------------------
package dcl_pkg;

    // Sample and position geometry.
    localparam int SAMPLE_BITS    = 10;
    localparam int POSITION_SHIFT = 5;
    localparam int POS_BITS       = 5;

    // Outer mode codes.
    localparam logic [2:0] MODE_IDLE   = 3'd0;
    localparam logic [2:0] MODE_RUN    = 3'd1;
    localparam logic [2:0] MODE_SOLVED = 3'd2;
    localparam logic [2:0] MODE_WON    = 3'd3;
    localparam logic [2:0] MODE_LOST   = 3'd4;

    // Lock stage codes.
    localparam logic [1:0] STAGE_FIRST  = 2'd0;
    localparam logic [1:0] STAGE_SECOND = 2'd1;
    localparam logic [1:0] STAGE_THIRD  = 2'd2;

    // Configuration register indexes.
    localparam int CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FIRST  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SECOND = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_THIRD  = 2'd2;

    // Configuration reset values.
    localparam logic [POS_BITS-1:0] FIRST_RESET  = 5'd5;
    localparam logic [POS_BITS-1:0] SECOND_RESET = 5'd10;
    localparam logic [POS_BITS-1:0] THIRD_RESET  = 5'd15;

    // Pass counter limit and the window of a backward turn.
    localparam logic [1:0]          PASS_MAX  = 2'd3;
    localparam logic [POS_BITS-1:0] BACK_NEAR = 5'd2;
    localparam logic [POS_BITS-1:0] BACK_FAR  = 5'd19;

    typedef logic [POS_BITS-1:0] t_pos;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] dial_sample;
        logic                   start_game;
        logic                   game_won;
        logic                   game_lost;
        logic                   skip_pressed;
    } t_in_word;

    typedef struct packed {
        t_pos first_number;
        t_pos second_number;
        t_pos third_number;
    } t_combo;

    typedef struct packed {
        logic [2:0] mode;
        logic [1:0] lock_stage;
        logic       module_complete;
        t_pos       shown_position;
        logic [1:0] shown_tens;
        logic [3:0] shown_ones;
    } t_result;

    // Tens digit of a position from 0 to 31.
    function automatic logic [1:0] pos_tens(input t_pos pos);
        logic [1:0] tens;
        if (pos >= 5'd30) begin
            tens = 2'd3;
        end else if (pos >= 5'd20) begin
            tens = 2'd2;
        end else if (pos >= 5'd10) begin
            tens = 2'd1;
        end else begin
            tens = 2'd0;
        end
        return tens;
    endfunction

    // Ones digit of a position from 0 to 31.
    function automatic logic [3:0] pos_ones(input t_pos pos);
        t_pos base;
        t_pos rest;
        case (pos_tens(pos))
            2'd3:    base = 5'd30;
            2'd2:    base = 5'd20;
            2'd1:    base = 5'd10;
            default: base = 5'd0;
        endcase
        rest = pos - base;
        return rest[3:0];
    endfunction

endpackage

>>> hw/rtl/dcl_in_if.sv
// ----------------------------------------------------------------------------
// Dial lock input channel
// Valid/ready channel that carries one debounce tick word.
// ----------------------------------------------------------------------------
interface dcl_in_if;
    logic                           valid;
    logic                           ready;
    logic [dcl_pkg::SAMPLE_BITS-1:0] dial_sample;
    logic                           start_game;
    logic                           game_won;
    logic                           game_lost;
    logic                           skip_pressed;

    modport source (
        output valid, dial_sample, start_game, game_won, game_lost, skip_pressed,
        input  ready
    );
    modport sink (
        input  valid, dial_sample, start_game, game_won, game_lost, skip_pressed,
        output ready
    );
endinterface

>>> hw/rtl/dcl_out_if.sv
// ----------------------------------------------------------------------------
// Dial lock output channel
// Valid/ready channel that carries one lock status word.
// ----------------------------------------------------------------------------
interface dcl_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] mode;
    logic [1:0] lock_stage;
    logic       module_complete;
    logic [4:0] shown_position;
    logic [1:0] shown_tens;
    logic [3:0] shown_ones;

    modport source (
        output valid, mode, lock_stage, module_complete, shown_position,
               shown_tens, shown_ones,
        input  ready
    );
    modport sink (
        input  valid, mode, lock_stage, module_complete, shown_position,
               shown_tens, shown_ones,
        output ready
    );
endinterface

>>> hw/rtl/dcl_in_reg.sv
// ----------------------------------------------------------------------------
// Dial lock input register
// Captures one tick word and holds it until the lock step consumes it.
// ----------------------------------------------------------------------------
module dcl_in_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    dcl_in_if.sink            i_in,
    input  logic              i_take,
    output logic              o_valid,
    output dcl_pkg::t_in_word o_word
);

    logic              r_valid;
    dcl_pkg::t_in_word r_word;

    // A held word leaves in the same cycle that a new one may enter.
    assign i_in.ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_word.dial_sample  <= i_in.dial_sample;
            r_word.start_game   <= i_in.start_game;
            r_word.game_won     <= i_in.game_won;
            r_word.game_lost    <= i_in.game_lost;
            r_word.skip_pressed <= i_in.skip_pressed;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

>>> hw/rtl/dcl_lock_step.sv
// ----------------------------------------------------------------------------
// Dial lock step
// Debounce, lock stage logic and outer mode machine for one tick word.
// ----------------------------------------------------------------------------
module dcl_lock_step (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  dcl_pkg::t_in_word i_word,
    input  dcl_pkg::t_combo   i_combo,
    output dcl_pkg::t_result  o_result
);

    dcl_pkg::t_pos r_last_raw, n_last_raw;
    dcl_pkg::t_pos r_stable,   n_stable;
    dcl_pkg::t_pos r_current,  n_current;
    dcl_pkg::t_pos r_prior,    n_prior;
    logic [1:0]    r_stage,    n_stage;
    logic [1:0]    r_pass,     n_pass;
    logic          r_seen,     n_seen;
    logic [2:0]    r_mode,     n_mode;

    logic [dcl_pkg::SAMPLE_BITS-1:0] shifted;
    dcl_pkg::t_pos                   raw;
    dcl_pkg::t_pos                   down_gap;
    logic                            back_down;
    logic                            back_up;

    assign shifted = i_word.dial_sample >> dcl_pkg::POSITION_SHIFT;
    assign raw     = shifted[dcl_pkg::POS_BITS-1:0];

    // Debounce: a position counts once two samples in a row agree.
    always_comb begin
        n_last_raw = raw;
        n_stable   = (raw == r_last_raw) ? raw : r_stable;
    end

    // Turn direction between the prior and current shown positions.
    dcl_pkg::t_pos pr;
    dcl_pkg::t_pos cu;

    always_comb begin
        if (r_current != n_stable) begin
            pr = r_current;
            cu = n_stable;
        end else begin
            pr = r_prior;
            cu = r_current;
        end
    end

    assign down_gap  = cu - pr;
    assign back_down = (cu > pr) && (down_gap >= dcl_pkg::BACK_NEAR)
                       && (down_gap <= dcl_pkg::BACK_FAR);
    assign back_up   = (pr > cu) && ((pr - cu) >= dcl_pkg::BACK_NEAR)
                       && ((pr - cu) <= dcl_pkg::BACK_FAR);

    always_comb begin
        n_current = cu;
        n_prior   = pr;
        n_stage   = r_stage;
        n_pass    = r_pass;
        n_seen    = r_seen;
        n_mode    = r_mode;
        case (r_mode)
            dcl_pkg::MODE_IDLE: begin
                n_stage = dcl_pkg::STAGE_FIRST;
                if (i_word.start_game) begin
                    n_mode = dcl_pkg::MODE_RUN;
                end
            end
            dcl_pkg::MODE_RUN: begin
                case (r_stage)
                    dcl_pkg::STAGE_FIRST: begin
                        if (back_down) begin
                            n_pass = 2'd0;
                        end
                        if (cu == i_combo.first_number) begin
                            n_seen = 1'b1;
                        end
                        if (pr == i_combo.first_number && n_seen) begin
                            if (n_pass != dcl_pkg::PASS_MAX) begin
                                n_pass = n_pass + 2'd1;
                            end
                            n_seen = 1'b0;
                        end
                        if (n_pass > 2'd1 && n_seen) begin
                            n_stage = dcl_pkg::STAGE_SECOND;
                            n_pass  = 2'd0;
                            n_seen  = 1'b0;
                            n_prior = cu;
                        end
                    end
                    dcl_pkg::STAGE_SECOND: begin
                        if (cu == i_combo.second_number) begin
                            n_seen = 1'b1;
                        end
                        if (pr == i_combo.second_number && n_seen) begin
                            if (n_pass != dcl_pkg::PASS_MAX) begin
                                n_pass = n_pass + 2'd1;
                            end
                            n_seen = 1'b0;
                        end
                        if (n_pass == 2'd1 && n_seen) begin
                            n_stage = dcl_pkg::STAGE_THIRD;
                            n_pass  = 2'd0;
                            n_seen  = 1'b0;
                            n_prior = cu;
                        end
                        // A reversal in the same tick overrides the advance.
                        if (back_up) begin
                            n_pass  = 2'd0;
                            n_seen  = 1'b0;
                            n_stage = dcl_pkg::STAGE_FIRST;
                        end
                    end
                    dcl_pkg::STAGE_THIRD: begin
                        if (cu == i_combo.third_number) begin
                            n_stage = dcl_pkg::STAGE_FIRST;
                            n_pass  = 2'd0;
                            n_mode  = dcl_pkg::MODE_SOLVED;
                        end
                        if (back_down) begin
                            n_stage = dcl_pkg::STAGE_FIRST;
                            n_pass  = 2'd0;
                        end
                    end
                    default: begin
                        n_stage = r_stage;
                    end
                endcase
                if (i_word.game_won) begin
                    n_mode = dcl_pkg::MODE_WON;
                end else if (i_word.game_lost) begin
                    n_mode = dcl_pkg::MODE_LOST;
                end else if (i_word.skip_pressed) begin
                    n_mode = dcl_pkg::MODE_SOLVED;
                end
            end
            dcl_pkg::MODE_SOLVED: begin
                if (i_word.game_won) begin
                    n_mode = dcl_pkg::MODE_WON;
                end else if (i_word.game_lost) begin
                    n_mode = dcl_pkg::MODE_LOST;
                end
            end
            default: begin
                n_mode = r_mode;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_raw <= '0;
            r_stable   <= '0;
            r_current  <= '0;
            r_prior    <= '0;
            r_stage    <= dcl_pkg::STAGE_FIRST;
            r_pass     <= 2'd0;
            r_seen     <= 1'b0;
            r_mode     <= dcl_pkg::MODE_IDLE;
        end else if (i_en) begin
            r_last_raw <= n_last_raw;
            r_stable   <= n_stable;
            r_current  <= n_current;
            r_prior    <= n_prior;
            r_stage    <= n_stage;
            r_pass     <= n_pass;
            r_seen     <= n_seen;
            r_mode     <= n_mode;
        end
    end

    always_comb begin
        o_result.mode            = n_mode;
        o_result.lock_stage      = n_stage;
        o_result.module_complete = (n_mode == dcl_pkg::MODE_SOLVED);
        o_result.shown_position  = n_stable;
        o_result.shown_tens      = dcl_pkg::pos_tens(n_stable);
        o_result.shown_ones      = dcl_pkg::pos_ones(n_stable);
    end

endmodule

>>> hw/rtl/dial_combination_lock_unit.sv
// ----------------------------------------------------------------------------
// Dial combination lock unit
// Debounces dial ticks, tracks the three-number combination and the game mode.
// ----------------------------------------------------------------------------
// The unit takes one debounce tick word per cycle on i_in and returns exactly
// one status word on o_out for each tick. A tick is first held in the input
// register; the lock step then updates the debounce, lock stage and mode
// state and loads the status word into the output register, so a status
// word reaches o_out through the input and output registers, and one tick per
// cycle is sustained while o_out.ready stays high. The single output register
// sets the rate under backpressure: the input register keeps taking words as
// long as the output register drains. The three combination numbers are to be
// written on the plain write port (index 0 first, 1 second, 2 third) while
// no word is in flight, unchecked by the unit; writes to index 3 are ignored.
// ----------------------------------------------------------------------------
module dial_combination_lock_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    dcl_in_if.sink                              i_in,
    dcl_out_if.source                           o_out,
    input  logic                                i_cfg_we,
    input  logic [dcl_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [dcl_pkg::POS_BITS-1:0]        i_cfg_data
);

    logic              held_valid;
    dcl_pkg::t_in_word held_word;
    logic              advance;
    dcl_pkg::t_combo   r_combo;
    dcl_pkg::t_result  step_result;
    dcl_pkg::t_result  r_result;
    logic              r_out_valid;

    // The held tick moves on whenever the output register is free or draining.
    assign advance = held_valid && (!r_out_valid || o_out.ready);

    dcl_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (advance),
        .o_valid (held_valid),
        .o_word  (held_word)
    );

    // Combination registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_combo.first_number  <= dcl_pkg::FIRST_RESET;
            r_combo.second_number <= dcl_pkg::SECOND_RESET;
            r_combo.third_number  <= dcl_pkg::THIRD_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                dcl_pkg::CFG_FIRST:  r_combo.first_number  <= i_cfg_data;
                dcl_pkg::CFG_SECOND: r_combo.second_number <= i_cfg_data;
                dcl_pkg::CFG_THIRD:  r_combo.third_number  <= i_cfg_data;
                default: begin
                    r_combo <= r_combo;
                end
            endcase
        end
    end

    dcl_lock_step u_lock_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance),
        .i_word   (held_word),
        .i_combo  (r_combo),
        .o_result (step_result)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= step_result;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.mode            = r_result.mode;
    assign o_out.lock_stage      = r_result.lock_stage;
    assign o_out.module_complete = r_result.module_complete;
    assign o_out.shown_position  = r_result.shown_position;
    assign o_out.shown_tens      = r_result.shown_tens;
    assign o_out.shown_ones      = r_result.shown_ones;

endmodule

>>> hw/rtl/dcl_checker.sv
// ----------------------------------------------------------------------------
// Dial lock port checker
// Concurrent checks on the status words seen at the unit's ports.
// ----------------------------------------------------------------------------
module dcl_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [2:0] i_mode,
    input logic [1:0] i_stage,
    input logic       i_complete,
    input logic [4:0] i_shown,
    input logic [1:0] i_tens,
    input logic [3:0] i_ones
);

    // The completion flag mirrors the solved mode.
    a_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_complete == (i_mode == dcl_pkg::MODE_SOLVED)))
        else $error("module_complete disagrees with mode");

    // The digits rebuild the shown position.
    a_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((7'(i_tens) * 7'd10 + 7'(i_ones)) == 7'(i_shown)))
        else $error("shown digits disagree with shown position");

    // In idle mode the lock always waits on the first number.
    a_idle_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_mode == dcl_pkg::MODE_IDLE)
        |-> (i_stage == dcl_pkg::STAGE_FIRST))
        else $error("lock stage not first while idle");

    // A stalled status word holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_mode)
        && $stable(i_stage) && $stable(i_shown)))
        else $error("stalled status word changed");

endmodule

bind dial_combination_lock_unit dcl_checker u_dcl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_mode      (o_out.mode),
    .i_stage     (o_out.lock_stage),
    .i_complete  (o_out.module_complete),
    .i_shown     (o_out.shown_position),
    .i_tens      (o_out.shown_tens),
    .i_ones      (o_out.shown_ones)
);

>>> tb/tb_dial_combination_lock_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dial combination lock unit testbench
// Sends debounce tick words to the lock and runs a bit-accurate copy of the
// lock alongside it. Every status word that comes back is compared field by
// field against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module tb_dial_combination_lock_unit;
    import dcl_pkg::*;

    localparam int RESET_CYCLES = 11;
    localparam int CYCLE_LIMIT  = 600000;
    // A status word passes the input and output registers after its tick is
    // taken; the pause covers anything still inside the pipeline.
    localparam int DRAIN_PAUSE  = 6;
    localparam int SOLVE_MOVES  = 400;
    localparam int HOLD_CYCLES  = 300;
    // Index 3 of the write port has no register behind it.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE = 2'd3;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    t_pos                      cfg_data;

    dcl_in_if  tick_if ();
    dcl_out_if status_if ();

    dial_combination_lock_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (tick_if),
        .o_out       (status_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the lock. It advances once per accepted tick word, in
    // the sending process, so the dial walker always steers from the state
    // that follows every word already handed over.
    // ------------------------------------------------------------------
    t_combo     combo;
    t_pos       raw_last;
    t_pos       stable_pos;
    t_pos       cur_pos;
    t_pos       prior_pos;
    logic [1:0] stage_q;
    logic [1:0] passes;
    logic       seen;
    logic [2:0] mode_q;

    // Predicted status words in the order the lock must return them.
    t_result expected_status[$];

    bit feed_gaps;
    bit sink_stalls;
    int hold_request;
    int ticks_sent;
    int error_count;
    int cycle_count;

    // A turn against the required direction by 2 to 19 positions. The
    // difference is taken as prior minus current without any wrap, so a
    // step across the 31/0 seam is judged by its unwrapped difference.
    function automatic bit reversed_down(input int delta);
        return delta < -1 && delta > -20;
    endfunction

    function automatic bit reversed_up(input int delta);
        return delta > 1 && delta < 20;
    endfunction

    // One step of the three-number lock. The turn is measured before any
    // stage change, and an advance to the next stage snaps the prior position
    // to the current one so the next step sees no turn unless the dial moves.
    task automatic lock_turn();
        int delta;
        delta = int'(prior_pos) - int'(cur_pos);
        case (stage_q)
            STAGE_FIRST: begin
                if (reversed_down(delta)) begin
                    passes = 2'd0;
                end
                if (cur_pos == combo.first_number) begin
                    seen = 1'b1;
                end
                if (prior_pos == combo.first_number && seen) begin
                    if (passes < PASS_MAX) begin
                        passes = passes + 2'd1;
                    end
                    seen = 1'b0;
                end
                if (passes > 2'd1 && seen) begin
                    stage_q   = STAGE_SECOND;
                    passes    = 2'd0;
                    seen      = 1'b0;
                    prior_pos = cur_pos;
                end
            end
            STAGE_SECOND: begin
                if (cur_pos == combo.second_number) begin
                    seen = 1'b1;
                end
                if (prior_pos == combo.second_number && seen) begin
                    if (passes < PASS_MAX) begin
                        passes = passes + 2'd1;
                    end
                    seen = 1'b0;
                end
                if (passes == 2'd1 && seen) begin
                    stage_q   = STAGE_THIRD;
                    passes    = 2'd0;
                    seen      = 1'b0;
                    prior_pos = cur_pos;
                end
                // A reversal in the same step as the advance still wins.
                if (reversed_up(delta)) begin
                    passes  = 2'd0;
                    seen    = 1'b0;
                    stage_q = STAGE_FIRST;
                end
            end
            STAGE_THIRD: begin
                if (cur_pos == combo.third_number) begin
                    stage_q = STAGE_FIRST;
                    passes  = 2'd0;
                    mode_q  = MODE_SOLVED;
                end
                // The seen flag is deliberately kept on this reset.
                if (reversed_down(delta)) begin
                    stage_q = STAGE_FIRST;
                    passes  = 2'd0;
                end
            end
            default: begin
            end
        endcase
    endtask

    // Debounce, mode machine and the status word for one tick.
    task automatic advance_lock(input t_in_word w, output t_result st);
        t_pos raw;
        raw = t_pos'(w.dial_sample >> POSITION_SHIFT);
        if (raw == raw_last) begin
            stable_pos = raw;
        end
        raw_last = raw;
        if (cur_pos != stable_pos) begin
            prior_pos = cur_pos;
            cur_pos   = stable_pos;
        end

        case (mode_q)
            MODE_IDLE: begin
                stage_q = STAGE_FIRST;
                if (w.start_game) begin
                    mode_q = MODE_RUN;
                end
            end
            MODE_RUN: begin
                // The lock step goes first; the flags then override it in
                // the order won, lost, skip.
                lock_turn();
                if (w.game_won) begin
                    mode_q = MODE_WON;
                end else if (w.game_lost) begin
                    mode_q = MODE_LOST;
                end else if (w.skip_pressed) begin
                    mode_q = MODE_SOLVED;
                end
            end
            MODE_SOLVED: begin
                if (w.game_won) begin
                    mode_q = MODE_WON;
                end else if (w.game_lost) begin
                    mode_q = MODE_LOST;
                end
            end
            default: begin
            end
        endcase

        st.mode            = mode_q;
        st.lock_stage      = stage_q;
        st.module_complete = (mode_q == MODE_SOLVED);
        st.shown_position  = stable_pos;
        st.shown_tens      = 2'(stable_pos / 5'd10);
        st.shown_ones      = 4'(stable_pos % 5'd10);
    endtask

    // Gap length for either side: mostly none, often short, now and then long.
    function automatic int pick_gap(input bit enable);
        int roll;
        roll = $urandom_range(0, 99);
        if (!enable || roll < 60) begin
            return 0;
        end else if (roll < 95) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic t_in_word tick_from_sample(input logic [SAMPLE_BITS-1:0] sample,
                                                  input bit start, input bit won,
                                                  input bit lost, input bit skip);
        t_in_word w;
        w.dial_sample  = sample;
        w.start_game   = start;
        w.game_won     = won;
        w.game_lost    = lost;
        w.skip_pressed = skip;
        return w;
    endfunction

    // A tick at a given dial position; the bits below the position are noise.
    function automatic t_in_word tick_at(input t_pos pos, input bit start, input bit won,
                                         input bit lost, input bit skip);
        logic [SAMPLE_BITS-1:0] low;
        low = SAMPLE_BITS'($urandom_range(0, (1 << POSITION_SHIFT) - 1));
        return tick_from_sample({pos, low[POSITION_SHIFT-1:0]}, start, won, lost, skip);
    endfunction

    // Hands one tick word to the lock. After the handshake valid is left as
    // it is: the next call or the caller drives it in this same step.
    task automatic send_tick(input t_in_word w);
        int      gap;
        t_result st;
        gap = pick_gap(feed_gaps);
        if (gap > 0) begin
            tick_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        tick_if.valid        <= 1'b1;
        tick_if.dial_sample  <= w.dial_sample;
        tick_if.start_game   <= w.start_game;
        tick_if.game_won     <= w.game_won;
        tick_if.game_lost    <= w.game_lost;
        tick_if.skip_pressed <= w.skip_pressed;
        do @(posedge i_clk); while (!(tick_if.valid && tick_if.ready));
        advance_lock(w, st);
        expected_status.push_back(st);
        ticks_sent++;
    endtask

    // Holds the dial at one position for a number of ticks.
    task automatic dial_at(input t_pos pos, input int reps);
        repeat (reps) send_tick(tick_at(pos, 1'($urandom_range(0, 1)), 1'b0, 1'b0, 1'b0));
    endtask

    task automatic wait_drained();
        tick_if.valid <= 1'b0;
        while (expected_status.size() != 0) @(posedge i_clk);
        repeat (DRAIN_PAUSE) @(posedge i_clk);
    endtask

    task automatic put_reg(input logic [CFG_INDEX_BITS-1:0] idx, input t_pos val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        case (idx)
            CFG_FIRST:  combo.first_number  = val;
            CFG_SECOND: combo.second_number = val;
            CFG_THIRD:  combo.third_number  = val;
            default: begin
            end
        endcase
    endtask

    // Rewrites the combination once the lock has nothing in flight. The
    // unused index gets a write too; the lock must ignore it.
    task automatic set_combo(input t_pos first, input t_pos second, input t_pos third);
        wait_drained();
        put_reg(CFG_FIRST, first);
        put_reg(CFG_SECOND, second);
        put_reg(CFG_THIRD, third);
        put_reg(CFG_SPARE, t_pos'($urandom));
        cfg_we <= 1'b0;
    endtask

    function automatic int wrap_pos(input int p);
        return ((p % 32) + 32) % 32;
    endfunction

    // One move of a player working the lock. The direction follows the
    // predicted stage: down for the first number, up for the second, and in
    // the third stage mostly a backward jump that throws the lock back. The
    // third number itself is never dialed here, so the lock cannot open by
    // accident. With resets allowed, some moves turn the wrong way on purpose,
    // including a jump that lands on the second number from two to nineteen
    // positions above it, which can hit the advance and the reversal together.
    task automatic dial_move(input bit allow_resets);
        int step;
        int goal;
        int above;
        int noise;
        above = int'(cur_pos) - int'(combo.second_number);
        case (stage_q)
            STAGE_FIRST: begin
                if (allow_resets && $urandom_range(0, 19) == 0) begin
                    step = $urandom_range(2, 19);
                end else begin
                    step = ($urandom_range(0, 3) == 0) ? -2 : -1;
                end
            end
            STAGE_SECOND: begin
                if (allow_resets && $urandom_range(0, 9) == 0) begin
                    if (above inside {[2:19]} && $urandom_range(0, 1) == 1) begin
                        step = -above;
                    end else begin
                        step = 0 - int'($urandom_range(2, 19));
                    end
                end else begin
                    step = ($urandom_range(0, 3) == 0) ? 2 : 1;
                end
            end
            default: begin
                if (allow_resets && $urandom_range(0, 9) < 7) begin
                    step = $urandom_range(2, 19);
                end else begin
                    step = -1;
                end
            end
        endcase
        goal = wrap_pos(int'(cur_pos) + step);
        if (goal == int'(combo.third_number)) begin
            goal = wrap_pos(goal + ((step < 0) ? -1 : 1));
        end
        // A stray single sample now and then, never at the third number.
        if ($urandom_range(0, 11) == 0) begin
            do noise = $urandom_range(0, 31); while (noise == int'(combo.third_number));
            send_tick(tick_at(t_pos'(noise), 1'($urandom_range(0, 1)), 1'b0, 1'b0, 1'b0));
        end
        dial_at(t_pos'(goal), $urandom_range(2, 3));
    endtask

    task automatic check_field(input string what, input int want, input int got);
        if (want != got) begin
            $display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
            error_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Idle mode: the dial extremes, debounce against single samples, the
    // digit split, and flags that idle mode must ignore.
    task automatic test_idle_directed();
        feed_gaps   = 1'b0;
        sink_stalls = 1'b0;
        send_tick(tick_from_sample(10'h000, 1'b0, 1'b0, 1'b0, 1'b0));
        send_tick(tick_from_sample(10'h3FF, 1'b0, 1'b1, 1'b1, 1'b1));
        send_tick(tick_from_sample(10'h3FF, 1'b0, 1'b0, 1'b0, 1'b0));
        send_tick(tick_from_sample(10'h3E0, 1'b0, 1'b0, 1'b1, 1'b0));
        send_tick(tick_from_sample(10'h01F, 1'b0, 1'b1, 1'b0, 1'b0));
        send_tick(tick_from_sample(10'h000, 1'b0, 1'b0, 1'b0, 1'b1));
        repeat (2) send_tick(tick_from_sample(10'h155, 1'b0, 1'b0, 1'b0, 1'b0));
        repeat (2) send_tick(tick_from_sample(10'h2AA, 1'b0, 1'b0, 1'b0, 1'b0));
        repeat (2) send_tick(tick_from_sample(10'h3BF, 1'b0, 1'b0, 1'b0, 1'b0));
        send_tick(tick_from_sample(10'h260, 1'b0, 1'b0, 1'b0, 1'b0));
    endtask

    // Start the game and make a few turns: a reversal in the first stage,
    // reaching the first number at zero and passing it across the seam.
    task automatic test_start_and_turns();
        set_combo(5'd0, 5'd31, 5'd16);
        send_tick(tick_from_sample(10'h260, 1'b1, 1'b0, 1'b0, 1'b0));
        dial_at(5'd20, 2);
        dial_at(5'd18, 2);
        dial_at(5'd22, 2);
        dial_at(5'd0, 2);
        dial_at(5'd31, 2);
    endtask

    // The sink holds off for a long stretch while ticks keep coming, so the
    // lock fills up and has to stall its input.
    task automatic test_backpressure();
        int stop_at;
        feed_gaps    = 1'b0;
        sink_stalls  = 1'b0;
        hold_request = HOLD_CYCLES;
        stop_at      = ticks_sent + 24;
        while (ticks_sent < stop_at) dial_move(1'b1);
    endtask

    // A stretch of random play under one combination.
    task automatic test_combo_walk(input t_pos first, input t_pos second, input t_pos third,
                                   input int count, input bit gaps);
        int stop_at;
        set_combo(first, second, third);
        feed_gaps   = gaps;
        sink_stalls = gaps;
        stop_at     = ticks_sent + count;
        while (ticks_sent < stop_at) dial_move(1'b1);
    endtask

    // Work the lock honestly up to the third stage, then dial the third
    // number with the skip button held on the settling tick. After that the
    // solved mode must ignore start and skip, and the closing flags end the
    // game for good.
    task automatic test_solve_and_finish();
        int moves;
        bit both;
        set_combo(5'd3, 5'd29, 5'd30);
        feed_gaps   = 1'b1;
        sink_stalls = 1'b1;
        moves       = 0;
        while (stage_q != STAGE_THIRD && moves < SOLVE_MOVES) begin
            dial_move(1'b0);
            moves++;
        end
        send_tick(tick_at(combo.third_number, 1'b0, 1'b0, 1'b0, 1'b0));
        send_tick(tick_at(combo.third_number, 1'b0, 1'b0, 1'b0, 1'b1));
        repeat (4) send_tick(tick_at(t_pos'($urandom), 1'b1, 1'b0, 1'b0, 1'b1));
        both = 1'($urandom_range(0, 1));
        send_tick(tick_at(t_pos'($urandom), 1'b0, both, 1'b1, 1'b0));
        send_tick(tick_at(t_pos'($urandom), 1'b1, !both, both, 1'b1));
    endtask

    // After the game is over only the dial display still moves; every
    // field is random here.
    task automatic test_final_noise(input int count);
        repeat (count) begin
            send_tick(tick_from_sample(SAMPLE_BITS'($urandom_range(0, 1023)),
                                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
        end
    endtask

    // ------------------------------------------------------------------
    // Clock, reset and sequencing
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n              = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = CFG_FIRST;
        cfg_data             = '0;
        tick_if.valid        = 1'b0;
        tick_if.dial_sample  = '0;
        tick_if.start_game   = 1'b0;
        tick_if.game_won     = 1'b0;
        tick_if.game_lost    = 1'b0;
        tick_if.skip_pressed = 1'b0;
        feed_gaps            = 1'b0;
        sink_stalls          = 1'b0;
        hold_request         = 0;
        ticks_sent           = 0;
        error_count          = 0;

        // Reset state of the shadow lock.
        combo.first_number  = FIRST_RESET;
        combo.second_number = SECOND_RESET;
        combo.third_number  = THIRD_RESET;
        raw_last   = '0;
        stable_pos = '0;
        cur_pos    = '0;
        prior_pos  = '0;
        stage_q    = STAGE_FIRST;
        passes     = 2'd0;
        seen       = 1'b0;
        mode_q     = MODE_IDLE;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_directed();
        test_start_and_turns();
        test_backpressure();
        test_combo_walk(FIRST_RESET, SECOND_RESET, THIRD_RESET, 330, 1'b1);
        test_combo_walk(5'd31, 5'd1, 5'd0, 320, 1'b0);
        test_combo_walk(5'd0, 5'd30, 5'd31, 320, 1'b1);
        test_combo_walk(5'd9, 5'd9, 5'd24, 320, 1'b1);
        test_solve_and_finish();
        test_final_noise(300);

        // Wait for every predicted word, then give the pipeline time to
        // show any extra word it should not produce.
        wait_drained();
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Sink side: random stalls, plus the long hold that the backpressure
    // test asks for, counted down here cycle by cycle.
    initial begin
        int stall_left;
        stall_left      = 0;
        status_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                stall_left   = hold_request;
                hold_request = 0;
            end
            if (stall_left > 0) begin
                status_if.ready <= 1'b0;
                stall_left--;
            end else begin
                stall_left = pick_gap(sink_stalls);
                status_if.ready <= (stall_left == 0);
                if (stall_left > 0) begin
                    stall_left--;
                end
            end
        end
    end

    // Every accepted status word is matched against the oldest prediction.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && status_if.valid && status_if.ready) begin
            if (expected_status.size() == 0) begin
                $display("%0t ns: status word expected none, got mode %0d position %0d",
                         $time, status_if.mode, status_if.shown_position);
                error_count++;
            end else begin
                want = expected_status.pop_front();
                check_field("mode", int'(want.mode), int'(status_if.mode));
                check_field("lock_stage", int'(want.lock_stage),
                            int'(status_if.lock_stage));
                check_field("module_complete", int'(want.module_complete),
                            int'(status_if.module_complete));
                check_field("shown_position", int'(want.shown_position),
                            int'(status_if.shown_position));
                check_field("shown_tens", int'(want.shown_tens),
                            int'(status_if.shown_tens));
                check_field("shown_ones", int'(want.shown_ones),
                            int'(status_if.shown_ones));
            end
        end
    end

    // Guard against a hung handshake.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial cycle_count = 0;

endmodule

>>> dial_combination_lock_unit.f
hw/rtl/dcl_pkg.sv
hw/rtl/dcl_in_if.sv
hw/rtl/dcl_out_if.sv
hw/rtl/dcl_in_reg.sv
hw/rtl/dcl_lock_step.sv
hw/rtl/dial_combination_lock_unit.sv
hw/rtl/dcl_checker.sv
tb/tb_dial_combination_lock_unit.sv
